// ===== design/plir_pkg.sv =====
// ----------------------------------------------------------------------------
// plir_pkg: shared types for the positional insert/read list
// Beat payloads, cell control bundle, operation and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package plir_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int CNT_OUT_W    = 7;
	localparam int GROUP        = 8;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_READ   = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_POSITION = 2'd1,
		ERR_FULL     = 2'd2
	} err_t;

	typedef struct packed {
		mode_t                     mode;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		logic [CNT_OUT_W-1:0]      count;
		logic                      empty_res;
		err_t                      error;
	} res_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic                      ins;
		logic                      rd;
		logic [POS_W-1:0]          idx;
		logic [DATA_W-1:0]         value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/plir_cell.sv =====
// ----------------------------------------------------------------------------
// plir_cell: one slot of the list
// Holds, loads the new value, or takes its left neighbor's value on insert;
// presents its slot on the read lanes when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module plir_cell #(
	parameter int IDX = 0
) (
	input  wire logic                       clk,
	input  wire plir_pkg::cell_ctl_t        ctl,
	input  wire logic [plir_pkg::DATA_W-1:0] left,
	output logic [plir_pkg::DATA_W-1:0]      slot,
	output logic [plir_pkg::DATA_W-1:0]      rd_lane
);

	logic [plir_pkg::DATA_W-1:0] slot_q;
	logic [plir_pkg::DATA_W-1:0] rd_s1;
	logic                        hit;
	logic                        above;

	assign hit   = (IDX == int'(ctl.idx));
	assign above = (IDX > int'(ctl.idx));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				slot_q <= ctl.value;
			end else if (above) begin
				slot_q <= left;
			end
		end
		rd_s1 <= (ctl.rd && hit) ? slot_q : '0;
	end

	assign slot    = slot_q;
	assign rd_lane = rd_s1;

endmodule

`default_nettype wire

// ===== design/plir_rd_tree.sv =====
// ----------------------------------------------------------------------------
// plir_rd_tree: read collection
// ORs the masked read lanes of all cells, one registered level per group.
// ----------------------------------------------------------------------------
`default_nettype none

module plir_rd_tree #(
	parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic [plir_pkg::DATA_W-1:0] lane [CAPACITY],
	output logic [plir_pkg::DATA_W-1:0]      rd
);

	localparam int NGRP = (CAPACITY + plir_pkg::GROUP - 1) / plir_pkg::GROUP;

	logic [plir_pkg::DATA_W-1:0] grp_or [NGRP];
	logic [plir_pkg::DATA_W-1:0] grp_s2 [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < plir_pkg::GROUP; k++) begin
				if (g * plir_pkg::GROUP + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | lane[g * plir_pkg::GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_s2[g] <= grp_or[g];
		end
	end

	always_comb begin
		rd = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd = rd | grp_s2[g];
		end
	end

endmodule

`default_nettype wire

// ===== design/positional_list_insert_read.sv =====
// A result beat is registered through the cell read register, the group OR
// register and the result register after the command beat is accepted.
// One command in flight at a time: cmd_ready is low until its result is taken.
// An insert loads its cell and shifts each cell above it on the accept edge.
// Reset: arst_n clears the element count and all handshake state; slot contents
// stay undefined until written, and never-written slots are never read.
// ----------------------------------------------------------------------------
// positional_list_insert_read: ordered list with positional insert and read
// Chain of slot cells with a shared control broadcast and OR read collection.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_read #(
	parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire plir_pkg::cmd_t cmd,
	output logic                res_valid,
	input  wire logic           res_ready,
	output plir_pkg::res_t      res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = ((CNT_W > plir_pkg::POS_W) ? CNT_W : plir_pkg::POS_W) + 1;

	logic [CNT_W-1:0]            count_q;
	logic                        busy_q;
	logic                        v_s1;
	logic                        v_s2;
	logic                        res_valid_q;
	plir_pkg::res_t              res_q;
	plir_pkg::res_t              meta_s1;
	plir_pkg::res_t              meta_s2;

	logic                        acc;
	logic [CW-1:0]               pos_w;
	logic [CW-1:0]               cnt_w;
	plir_pkg::err_t              err;
	logic [CNT_W-1:0]            count_nxt;
	plir_pkg::cell_ctl_t         ctl;
	logic [plir_pkg::DATA_W-1:0] slot    [CAPACITY];
	logic [plir_pkg::DATA_W-1:0] rd_lane [CAPACITY];
	logic [plir_pkg::DATA_W-1:0] rd_val;

	assign cmd_ready = !busy_q;
	assign acc       = cmd_valid && cmd_ready;
	assign pos_w     = CW'(cmd.position);
	assign cnt_w     = CW'(count_q);

	always_comb begin
		err = plir_pkg::ERR_OK;
		unique case (cmd.mode)
			plir_pkg::MODE_INSERT: begin
				if (cmd.position == '0 || pos_w > cnt_w + CW'(1)) begin
					err = plir_pkg::ERR_POSITION;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					err = plir_pkg::ERR_FULL;
				end
			end
			plir_pkg::MODE_READ: begin
				if (cmd.position == '0 || pos_w > cnt_w) begin
					err = plir_pkg::ERR_POSITION;
				end
			end
			default: err = plir_pkg::ERR_POSITION;
		endcase
	end

	always_comb begin
		ctl.ins   = acc && cmd.mode == plir_pkg::MODE_INSERT && err == plir_pkg::ERR_OK;
		ctl.rd    = acc && cmd.mode == plir_pkg::MODE_READ && err == plir_pkg::ERR_OK;
		ctl.idx   = cmd.position - plir_pkg::POS_W'(1);
		ctl.value = cmd.value;
		count_nxt = ctl.ins ? count_q + CNT_W'(1) : count_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			plir_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.left    ('0),
				.slot    (slot[i]),
				.rd_lane (rd_lane[i])
			);
		end else begin : g_body
			plir_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.left    (slot[i-1]),
				.slot    (slot[i]),
				.rd_lane (rd_lane[i])
			);
		end
	end

	plir_rd_tree #(.CAPACITY(CAPACITY)) u_rd_tree (
		.clk  (clk),
		.lane (rd_lane),
		.rd   (rd_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			v_s1    <= acc;
			v_s2    <= v_s1;
			if (acc) begin
				busy_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				busy_q <= 1'b0;
			end
			// hold the result until its beat goes out
			if (v_s2) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1.read_value <= '0;
			meta_s1.count      <= plir_pkg::CNT_OUT_W'(count_nxt);
			meta_s1.empty_res  <= (count_nxt == '0);
			meta_s1.error      <= err;
		end
		if (v_s1) begin
			meta_s2 <= meta_s1;
		end
		if (v_s2) begin
			res_q.read_value <= rd_val;
			res_q.count      <= meta_s2.count;
			res_q.empty_res  <= meta_s2.empty_res;
			res_q.error      <= meta_s2.error;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2 && !v_s1)
		else $error("pipeline stage 1 did not advance");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, res_valid_q}))
		else $error("more than one command in flight");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("count did not advance on insert");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count exceeds capacity");

	a_err_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.error != plir_pkg::ERR_OK |-> res_q.read_value == '0)
		else $error("failed command carries read data");

endmodule

`default_nettype wire
